@@ design/ubps_pkg.sv @@
// ----------------------------------------------------------------------------
// ubps_pkg
// types and constants shared by the bulk pair descriptor scan unit
// ----------------------------------------------------------------------------
package ubps_pkg;

   localparam logic [7:0]  TYPE_CONFIG    = 8'h02;
   localparam logic [7:0]  TYPE_INTERFACE = 8'h04;
   localparam logic [7:0]  TYPE_ENDPOINT  = 8'h05;
   localparam logic [1:0]  XFER_BULK      = 2'd2;
   localparam logic [10:0] SIZE_MAX_OK    = 11'd1024;
   localparam logic [7:0]  MIN_CFG_LEN    = 8'd9;
   localparam logic [7:0]  MIN_IF_LEN     = 8'd9;
   localparam logic [7:0]  MIN_EP_LEN     = 8'd7;
   localparam logic [7:0]  MIN_DESC_LEN   = 8'd2;
   localparam logic [15:0] MIN_BYTES_OK   = 16'd9;
   localparam logic [15:0] BYTES_MAX      = 16'hFFFF;
   localparam logic [7:0]  OUT_EP_RESET   = 8'h02;
   localparam logic [7:0]  IN_EP_RESET    = 8'h81;

   typedef enum logic [0:0] {
      CSR_OUT_EP = 1'b0,
      CSR_IN_EP  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } item_type;

   typedef struct packed {
      logic fail;
      logic have_if;
      logic recorded;
      logic found;
   } flags_type;

   typedef struct packed {
      logic        found;
      logic [7:0]  iface_number;
      logic [7:0]  alt_setting;
      logic [7:0]  bulk_out_endpoint;
      logic [7:0]  bulk_in_endpoint;
      logic [10:0] out_packet_size;
      logic [10:0] in_packet_size;
   } result_type;

   typedef struct packed {
      logic [15:0] bytes_seen;
      logic [15:0] total_length;
      logic [7:0]  header_length;
      logic [15:0] desc_start;
      logic [7:0]  desc_length;
      logic [7:0]  desc_type;
      logic [23:0] field_bytes;
      flags_type   flags;
      logic [7:0]  if_num;
      logic [7:0]  if_alt;
      logic [7:0]  ep_out;
      logic [7:0]  ep_in;
      logic [10:0] out_mps;
      logic [10:0] in_mps;
      result_type  match;
   } scan_type;

   typedef struct packed {
      logic       emit;
      result_type word;
   } emit_type;

endpackage

@@ design/ubps_in_reg.sv @@
// ----------------------------------------------------------------------------
// ubps_in_reg
// input register for descriptor bytes, holds one word until the scan takes it
// ----------------------------------------------------------------------------
module ubps_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   output logic               req_stall,
   input  logic               advance,
   output ubps_pkg::item_type item
);

   ubps_pkg::item_type item_ff;

   assign req_stall = item_ff.valid & ~advance;
   assign item      = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (!req_stall) begin
         item_ff.valid <= req_valid;
         item_ff.data  <= req_data_byte;
         item_ff.last  <= req_last_byte;
      end
   end

endmodule

@@ design/ubps_parser.sv @@
// ----------------------------------------------------------------------------
// ubps_parser
// descriptor chain walker, endpoint pair matcher and verdict builder
// ----------------------------------------------------------------------------
module ubps_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [0:0]         csr_index,
   input  logic [7:0]         csr_write_data,
   input  logic               advance,
   input  ubps_pkg::item_type item,
   output ubps_pkg::emit_type emit
);

   ubps_pkg::scan_type scan_ff;
   ubps_pkg::scan_type scan_in;
   logic [7:0]  out_ep_ff;
   logic [7:0]  in_ep_ff;

   logic [15:0] rel_raw;
   logic        at_next;
   logic [15:0] rel;
   logic [16:0] end_two;
   logic [16:0] end_len;

   logic [7:0]  ep_addr;
   logic [10:0] ep_mps;
   logic        ep_bulk;
   logic        ep_size_bad;
   logic        ep_dup;
   logic [10:0] ep_out_m;
   logic [10:0] ep_in_m;
   logic [7:0]  ep_out_a;
   logic [7:0]  ep_in_a;
   logic        ep_pair;
   logic        ok;

   // descriptor position
   assign rel_raw = scan_ff.bytes_seen - scan_ff.desc_start;
   assign at_next = (rel_raw == {8'h00, scan_ff.desc_length});
   assign rel     = at_next ? 16'd0 : rel_raw;
   assign end_two = {1'b0, scan_ff.bytes_seen} + 17'd2;
   assign end_len = {1'b0, scan_ff.bytes_seen} + {9'h000, item.data};

   // endpoint descriptor completion
   assign ep_addr     = scan_ff.field_bytes[7:0];
   assign ep_mps      = {item.data[2:0], scan_ff.field_bytes[23:16]};
   assign ep_bulk     = (scan_ff.field_bytes[9:8] == ubps_pkg::XFER_BULK);
   assign ep_size_bad = (ep_mps == 11'd0) || (ep_mps > ubps_pkg::SIZE_MAX_OK);

   always_comb begin
      ep_dup   = 1'b0;
      ep_out_m = scan_ff.out_mps;
      ep_in_m  = scan_ff.in_mps;
      ep_out_a = scan_ff.ep_out;
      ep_in_a  = scan_ff.ep_in;
      if (ep_addr == out_ep_ff) begin
         if (scan_ff.out_mps != 11'd0) begin
            ep_dup = 1'b1;
         end else begin
            ep_out_m = ep_mps;
            ep_out_a = ep_addr;
         end
      end else if (ep_addr == in_ep_ff) begin
         if (scan_ff.in_mps != 11'd0) begin
            ep_dup = 1'b1;
         end else begin
            ep_in_m = ep_mps;
            ep_in_a = ep_addr;
         end
      end
      ep_pair = !scan_ff.flags.recorded && (scan_ff.if_alt == 8'h00) &&
                (ep_out_m != 11'd0) && (ep_in_m != 11'd0);
   end

   always_comb begin
      scan_in   = scan_ff;
      emit.emit = 1'b0;
      emit.word = '0;
      ok        = 1'b0;
      if (advance) begin
         if (!scan_ff.flags.fail) begin
            if (scan_ff.bytes_seen < 16'd4) begin
               case (scan_ff.bytes_seen[1:0])
                  2'd0: begin
                     scan_in.header_length = item.data;
                     scan_in.desc_start    = 16'd0;
                     scan_in.desc_length   = item.data;
                     scan_in.desc_type     = ubps_pkg::TYPE_CONFIG;
                     if (item.data < ubps_pkg::MIN_CFG_LEN) scan_in.flags.fail = 1'b1;
                  end
                  2'd1: begin
                     if (item.data != ubps_pkg::TYPE_CONFIG) scan_in.flags.fail = 1'b1;
                  end
                  2'd2: begin
                     scan_in.total_length = {8'h00, item.data};
                  end
                  default: begin
                     scan_in.total_length = {item.data, scan_ff.total_length[7:0]};
                     if ({item.data, scan_ff.total_length[7:0]} <
                         {8'h00, scan_ff.header_length}) begin
                        scan_in.flags.fail = 1'b1;
                     end
                  end
               endcase
            end else if (scan_ff.bytes_seen < scan_ff.total_length) begin
               if (at_next) scan_in.desc_start = scan_ff.bytes_seen;
               if (rel == 16'd0) begin
                  scan_in.desc_length = item.data;
                  scan_in.desc_type   = 8'h00;
                  if ((end_two > {1'b0, scan_ff.total_length}) ||
                      (item.data < ubps_pkg::MIN_DESC_LEN) ||
                      (end_len > {1'b0, scan_ff.total_length})) begin
                     scan_in.flags.fail = 1'b1;
                  end
               end else if (rel == 16'd1) begin
                  scan_in.desc_type = item.data;
                  if ((item.data == ubps_pkg::TYPE_INTERFACE) &&
                      (scan_ff.desc_length < ubps_pkg::MIN_IF_LEN)) begin
                     scan_in.flags.fail = 1'b1;
                  end
                  if ((item.data == ubps_pkg::TYPE_ENDPOINT) &&
                      ((scan_ff.desc_length < ubps_pkg::MIN_EP_LEN) ||
                       !scan_ff.flags.have_if)) begin
                     scan_in.flags.fail = 1'b1;
                  end
               end else if (scan_ff.desc_type == ubps_pkg::TYPE_INTERFACE) begin
                  if (rel == 16'd2) begin
                     scan_in.field_bytes = {16'h0000, item.data};
                  end else if (rel == 16'd3) begin
                     scan_in.flags.have_if  = 1'b1;
                     scan_in.flags.recorded = 1'b0;
                     scan_in.if_num         = scan_ff.field_bytes[7:0];
                     scan_in.if_alt         = item.data;
                     scan_in.ep_out         = 8'h00;
                     scan_in.ep_in          = 8'h00;
                     scan_in.out_mps        = 11'd0;
                     scan_in.in_mps         = 11'd0;
                  end
               end else if (scan_ff.desc_type == ubps_pkg::TYPE_ENDPOINT) begin
                  if (rel == 16'd2) begin
                     scan_in.field_bytes = {16'h0000, item.data};
                  end else if (rel == 16'd3) begin
                     scan_in.field_bytes = {8'h00, item.data, scan_ff.field_bytes[7:0]};
                  end else if (rel == 16'd4) begin
                     scan_in.field_bytes = {item.data, scan_ff.field_bytes[15:0]};
                  end else if ((rel == 16'd5) && ep_bulk) begin
                     if (ep_size_bad || ep_dup) begin
                        scan_in.flags.fail = 1'b1;
                     end else begin
                        scan_in.out_mps = ep_out_m;
                        scan_in.in_mps  = ep_in_m;
                        scan_in.ep_out  = ep_out_a;
                        scan_in.ep_in   = ep_in_a;
                        if (ep_pair) begin
                           if (scan_ff.flags.found) begin
                              scan_in.flags.fail = 1'b1;
                           end else begin
                              scan_in.match.found             = 1'b1;
                              scan_in.match.iface_number      = scan_ff.if_num;
                              scan_in.match.alt_setting       = scan_ff.if_alt;
                              scan_in.match.bulk_out_endpoint = ep_out_a;
                              scan_in.match.bulk_in_endpoint  = ep_in_a;
                              scan_in.match.out_packet_size   = ep_out_m;
                              scan_in.match.in_packet_size    = ep_in_m;
                              scan_in.flags.found             = 1'b1;
                              scan_in.flags.recorded          = 1'b1;
                           end
                        end
                     end
                  end
               end
            end
         end
         if (scan_ff.bytes_seen != ubps_pkg::BYTES_MAX) begin
            scan_in.bytes_seen = scan_ff.bytes_seen + 16'd1;
         end
         if (item.last) begin
            ok = !scan_in.flags.fail && scan_in.flags.found &&
                 (scan_in.bytes_seen >= ubps_pkg::MIN_BYTES_OK) &&
                 (scan_in.total_length <= scan_in.bytes_seen);
            emit.emit = 1'b1;
            if (ok) emit.word = scan_in.match;
            scan_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else begin
         scan_ff <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ep_ff <= ubps_pkg::OUT_EP_RESET;
         in_ep_ff  <= ubps_pkg::IN_EP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            ubps_pkg::CSR_OUT_EP: out_ep_ff <= csr_write_data;
            ubps_pkg::CSR_IN_EP:  in_ep_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

endmodule

@@ design/ubps_out_reg.sv @@
// ----------------------------------------------------------------------------
// ubps_out_reg
// result register, holds one verdict word until the receiver takes it
// ----------------------------------------------------------------------------
module ubps_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  ubps_pkg::emit_type emit,
   output logic               out_free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic [7:0]         rsp_iface_number,
   output logic [7:0]         rsp_alt_setting,
   output logic [7:0]         rsp_bulk_out_endpoint,
   output logic [7:0]         rsp_bulk_in_endpoint,
   output logic [10:0]        rsp_out_packet_size,
   output logic [10:0]        rsp_in_packet_size
);

   logic                 rsp_valid_ff;
   ubps_pkg::result_type rsp_word_ff;

   assign out_free              = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_found             = rsp_word_ff.found;
   assign rsp_iface_number      = rsp_word_ff.iface_number;
   assign rsp_alt_setting       = rsp_word_ff.alt_setting;
   assign rsp_bulk_out_endpoint = rsp_word_ff.bulk_out_endpoint;
   assign rsp_bulk_in_endpoint  = rsp_word_ff.bulk_in_endpoint;
   assign rsp_out_packet_size   = rsp_word_ff.out_packet_size;
   assign rsp_in_packet_size    = rsp_word_ff.in_packet_size;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.emit) begin
         rsp_word_ff <= emit.word;
      end
   end

endmodule

@@ design/usb_bulk_pair_descriptor_scan_unit.sv @@
// ----------------------------------------------------------------------------
// usb_bulk_pair_descriptor_scan_unit
// Takes a configuration descriptor set one byte per word and gives one verdict
// word on the byte marked last. A byte is taken every cycle unless stalled: it
// passes an input register and is folded into the scan state; on a last byte
// the verdict goes into the result register, so these two registers lie
// between an accepted last byte and its verdict. Bytes stop being taken only
// while a last byte waits behind a verdict that the receiver still stalls. The
// user is to write the bulk OUT and IN endpoint addresses through the csr port
// while the unit is idle (unenforced); the scan state restarts after a verdict.
// ----------------------------------------------------------------------------
module usb_bulk_pair_descriptor_scan_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [7:0]  rsp_iface_number,
   output logic [7:0]  rsp_alt_setting,
   output logic [7:0]  rsp_bulk_out_endpoint,
   output logic [7:0]  rsp_bulk_in_endpoint,
   output logic [10:0] rsp_out_packet_size,
   output logic [10:0] rsp_in_packet_size
);

   ubps_pkg::item_type item;
   ubps_pkg::emit_type emit;
   logic               out_free;
   logic               advance;

   assign advance = item.valid & (~item.last | out_free);

   ubps_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_stall     (req_stall),
      .advance       (advance),
      .item          (item)
   );

   ubps_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .advance          (advance),
      .item             (item),
      .emit             (emit)
   );

   ubps_out_reg u_out_reg (
      .clock                 (clock),
      .reset                 (reset),
      .emit                  (emit),
      .out_free              (out_free),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_found             (rsp_found),
      .rsp_iface_number      (rsp_iface_number),
      .rsp_alt_setting       (rsp_alt_setting),
      .rsp_bulk_out_endpoint (rsp_bulk_out_endpoint),
      .rsp_bulk_in_endpoint  (rsp_bulk_in_endpoint),
      .rsp_out_packet_size   (rsp_out_packet_size),
      .rsp_in_packet_size    (rsp_in_packet_size)
   );

endmodule

@@ design/ubps_checker.sv @@
// ----------------------------------------------------------------------------
// ubps_checker
// port level checks for the bulk pair descriptor scan unit
// ----------------------------------------------------------------------------
module ubps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_found,
   input logic [7:0]  rsp_iface_number,
   input logic [7:0]  rsp_alt_setting,
   input logic [7:0]  rsp_bulk_out_endpoint,
   input logic [7:0]  rsp_bulk_in_endpoint,
   input logic [10:0] rsp_out_packet_size,
   input logic [10:0] rsp_in_packet_size
);

   // stalled verdict holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_iface_number) && $stable(rsp_out_packet_size))
      else $error("stalled verdict changed");

   // no match means an all zero word
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_iface_number == 8'h00 &&
      rsp_alt_setting == 8'h00 && rsp_bulk_out_endpoint == 8'h00 &&
      rsp_bulk_in_endpoint == 8'h00 && rsp_out_packet_size == 11'd0 &&
      rsp_in_packet_size == 11'd0)
      else $error("miss verdict carries match fields");

   // a match is in alternate 0 with legal sizes and distinct endpoints
   a_match_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_alt_setting == 8'h00 &&
      rsp_out_packet_size != 11'd0 && rsp_out_packet_size <= 11'd1024 &&
      rsp_in_packet_size != 11'd0 && rsp_in_packet_size <= 11'd1024 &&
      rsp_bulk_out_endpoint != rsp_bulk_in_endpoint)
      else $error("illegal match verdict");

   // input stalls only behind a stalled verdict
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with the verdict register free");

   // nothing left over from before reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("verdict valid after reset");

endmodule

bind usb_bulk_pair_descriptor_scan_unit ubps_checker u_ubps_checker (.*);
